@@ design/tsa_pkg.sv @@
// Shared types and constants for the triangle stiffness assembly block.
// Holds field widths, stream packing sizes, the pair tag and saturation limits.
// No dependencies.
package tsa_pkg;

    localparam int unsigned GRAD_W     = 32;
    localparam int unsigned NODE_W     = 6;
    localparam int unsigned NODE_SPAN  = 1 << NODE_W;
    localparam int unsigned ENTRY_W    = 48;
    localparam int unsigned ADDR_MAX_W = 2 * NODE_W;

    localparam int unsigned S_TDATA_W = 248;
    localparam int unsigned S_TUSER_W = 2;
    localparam int unsigned M_TDATA_W = 56;

    localparam int unsigned NODE_BASE = 7 * GRAD_W;
    localparam int unsigned DET_BASE  = 6 * GRAD_W;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam logic [1:0] IDX_FIRST  = 2'd0;
    localparam logic [1:0] IDX_SECOND = 2'd1;
    localparam logic [1:0] IDX_LAST   = 2'd2;

    localparam logic [ENTRY_W-1:0] ENTRY_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [ENTRY_W-1:0] ENTRY_MIN = 48'h8000_0000_0000;

    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_0100_0000;
    localparam logic [63:0] HI_LIMIT   = 64'h0000_0200_0000_0000;

    typedef struct packed {
        logic                  v;
        logic                  rd;
        logic                  ok;
        logic [ADDR_MAX_W-1:0] addr;
    } pair_tag_t;

endpackage

@@ design/tsa_entry_pipe.sv @@
// Four-stage pipeline that forms one local stiffness entry in Q24.24.
// Carries a pair tag alongside the data; depends on tsa_pkg.
module tsa_entry_pipe
    import tsa_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  pair_tag_t                 in_tag,
    input  logic signed [GRAD_W-1:0]  gx_i,
    input  logic signed [GRAD_W-1:0]  gx_j,
    input  logic signed [GRAD_W-1:0]  gy_i,
    input  logic signed [GRAD_W-1:0]  gy_j,
    input  logic        [GRAD_W-1:0]  abs_det,
    output pair_tag_t                 mid_tag,
    output pair_tag_t                 out_tag,
    output logic signed [ENTRY_W-1:0] out_loc,
    output logic                      out_sat
);

    pair_tag_t                tag1_reg, tag2_reg, tag3_reg, tag4_reg;
    logic signed [63:0]       p1_reg, p2_reg;
    logic signed [63:0]       p1_next, p2_next;
    logic [GRAD_W-1:0]        det1_reg, det2_reg;
    logic signed [64:0]       sum2;
    logic [63:0]              mag2_reg, mag2_next;
    logic                     neg2_reg, neg3_reg;
    logic [63:0]              hi3_reg, lo3_reg, hi3_next, lo3_next;
    logic [63:0]              lo_round;
    logic [49:0]              r4;
    logic [ENTRY_W-1:0]       limit4, mag4;
    logic                     sat4;
    logic signed [ENTRY_W-1:0] loc4_reg;
    logic                     sat4_reg;

    assign p1_next = gx_i * gx_j;
    assign p2_next = gy_i * gy_j;

    assign sum2      = 65'(p1_reg) + 65'(p2_reg);
    assign mag2_next = sum2[64] ? 64'(-sum2) : sum2[63:0];

    assign hi3_next = 64'(mag2_reg[63:32]) * 64'(det2_reg);
    assign lo3_next = 64'(mag2_reg[31:0]) * 64'(det2_reg);

    assign lo_round = lo3_reg + ROUND_HALF;
    assign r4       = {1'b0, hi3_reg[41:0], 7'b0} + {11'b0, lo_round[63:25]};
    assign limit4   = neg3_reg ? ENTRY_MIN : ENTRY_MAX;
    assign sat4     = (hi3_reg > HI_LIMIT) || (r4 > {2'b0, limit4});
    assign mag4     = sat4 ? limit4 : r4[ENTRY_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
            tag4_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
            tag4_reg <= tag3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        p1_reg   <= p1_next;
        p2_reg   <= p2_next;
        det1_reg <= abs_det;
        mag2_reg <= mag2_next;
        neg2_reg <= sum2[64];
        det2_reg <= det1_reg;
        hi3_reg  <= hi3_next;
        lo3_reg  <= lo3_next;
        neg3_reg <= neg2_reg;
        loc4_reg <= neg3_reg ? (~mag4 + 48'd1) : mag4;
        sat4_reg <= sat4;
    end

    assign mid_tag = tag3_reg;
    assign out_tag = tag4_reg;
    assign out_loc = loc4_reg;
    assign out_sat = sat4_reg;

endmodule

@@ design/triangle_stiffness_assembly.sv @@
// Linear triangle stiffness assembly into a saturating on-chip global matrix.
// Top level; depends on tsa_pkg and tsa_entry_pipe.
//
// After reset the block sweeps its matrix memory to zero, one entry per cycle,
// and takes no request until that is done. A triangle add request then issues
// its nine local entries one per cycle into a pipelined path that ends in a
// read-modify-write of the single matrix memory; an add request that is not a
// triangle issues no entries. A read request issues one entry through the entry
// pipeline and the memory read port, its result is registered onto the output
// stream, and only one read is outstanding at a time.
module triangle_stiffness_assembly
    import tsa_pkg::*;
#(
    parameter int unsigned NODES = 64
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // grad_x0, grad_y0, grad_x1, grad_y1, grad_x2, grad_y2, jac_det, node_a,
    // node_b, node_c, zero fill.
    input  logic [S_TDATA_W-1:0] s_tdata,
    // mode, is_triangle.
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // entry_value, overflow_seen, zero fill.
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int unsigned NODE_LIM = (NODES < NODE_SPAN) ? NODES : NODE_SPAN;
    localparam int unsigned DEPTH    = NODE_LIM * NODE_LIM;
    localparam int unsigned ADDR_W   = $clog2(DEPTH);

    localparam logic ST_CLEAR = 1'b0;
    localparam logic ST_RUN   = 1'b1;

    logic                     state_reg;
    logic [ADDR_W-1:0]        clr_addr_reg;

    logic signed [GRAD_W-1:0] gx_reg [3];
    logic signed [GRAD_W-1:0] gy_reg [3];
    logic [NODE_W-1:0]        node_reg [3];
    logic [GRAD_W-1:0]        absdet_reg;
    logic [GRAD_W-1:0]        absdet_next;
    logic signed [GRAD_W-1:0] det_in;

    logic                     busy_reg;
    logic                     rdi_reg;
    logic [1:0]               pi_reg, pj_reg;
    logic                     last_pair;
    logic                     accept;
    logic                     rd_inflight_reg;

    logic [NODE_W-1:0]        row, col;
    pair_tag_t                issue_tag;
    pair_tag_t                mid_tag, out_tag;
    logic signed [ENTRY_W-1:0] out_loc;
    logic                     out_sat;

    logic [ENTRY_W-1:0]       store_mem [DEPTH];
    logic [ENTRY_W-1:0]       mem_q_reg;
    logic                     fwd_v_reg;
    logic [ADDR_MAX_W-1:0]    fwd_addr_reg;
    logic [ENTRY_W-1:0]       fwd_data_reg;

    logic [ENTRY_W-1:0]       old_val;
    logic [ENTRY_W:0]         sum5;
    logic                     add_sat;
    logic [ENTRY_W-1:0]       new_val;
    logic                     wr_en, rd_out;
    logic                     ovf_reg;

    logic                     m_tvalid_reg;
    logic [ENTRY_W-1:0]       m_data_reg;
    logic                     m_ovf_reg;

    assign last_pair = rdi_reg || (pi_reg == IDX_LAST && pj_reg == IDX_LAST);
    assign s_tready  = (state_reg == ST_RUN) && (!busy_reg || last_pair)
                       && (s_tuser[0] == MODE_ADD || (!rd_inflight_reg && !m_tvalid_reg));
    assign accept    = s_tvalid && s_tready;

    assign det_in      = s_tdata[DET_BASE +: GRAD_W];
    assign absdet_next = det_in[GRAD_W-1] ? GRAD_W'(-det_in) : det_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
        end else if (state_reg == ST_CLEAR) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(DEPTH - 1)) begin
                state_reg <= ST_RUN;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < 3; k++) begin
                gx_reg[k]   <= s_tdata[(2 * k) * GRAD_W +: GRAD_W];
                gy_reg[k]   <= s_tdata[(2 * k + 1) * GRAD_W +: GRAD_W];
                node_reg[k] <= s_tdata[NODE_BASE + k * NODE_W +: NODE_W];
            end
            absdet_reg <= absdet_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            rdi_reg  <= 1'b0;
            pi_reg   <= IDX_FIRST;
            pj_reg   <= IDX_FIRST;
        end else if (accept) begin
            rdi_reg <= (s_tuser[0] == MODE_READ);
            pi_reg  <= IDX_FIRST;
            if (s_tuser[0] == MODE_READ) begin
                busy_reg <= 1'b1;
                pj_reg   <= IDX_SECOND;
            end else begin
                busy_reg <= s_tuser[1];
                pj_reg   <= IDX_FIRST;
            end
        end else if (busy_reg) begin
            if (last_pair) begin
                busy_reg <= 1'b0;
            end else if (pj_reg == IDX_LAST) begin
                pj_reg <= IDX_FIRST;
                pi_reg <= pi_reg + 2'd1;
            end else begin
                pj_reg <= pj_reg + 2'd1;
            end
        end
    end

    assign row = node_reg[pi_reg];
    assign col = node_reg[pj_reg];

    always_comb begin
        issue_tag.v    = busy_reg;
        issue_tag.rd   = rdi_reg;
        issue_tag.ok   = (32'(row) < NODES) && (32'(col) < NODES);
        issue_tag.addr = ADDR_MAX_W'(32'(row) * NODE_LIM + 32'(col));
    end

    tsa_entry_pipe u_pipe (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (issue_tag),
        .gx_i    (gx_reg[pi_reg]),
        .gx_j    (gx_reg[pj_reg]),
        .gy_i    (gy_reg[pi_reg]),
        .gy_j    (gy_reg[pj_reg]),
        .abs_det (absdet_reg),
        .mid_tag (mid_tag),
        .out_tag (out_tag),
        .out_loc (out_loc),
        .out_sat (out_sat)
    );

    assign old_val = (fwd_v_reg && fwd_addr_reg == out_tag.addr) ? fwd_data_reg : mem_q_reg;
    assign sum5    = {old_val[ENTRY_W-1], old_val} + {out_loc[ENTRY_W-1], out_loc};
    assign add_sat = sum5[ENTRY_W] != sum5[ENTRY_W-1];
    assign new_val = add_sat ? (sum5[ENTRY_W] ? ENTRY_MIN : ENTRY_MAX) : sum5[ENTRY_W-1:0];
    assign wr_en   = out_tag.v && !out_tag.rd && out_tag.ok;
    assign rd_out  = out_tag.v && out_tag.rd;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_CLEAR) begin
            store_mem[clr_addr_reg] <= '0;
        end else if (wr_en) begin
            store_mem[out_tag.addr[ADDR_W-1:0]] <= new_val;
        end
        mem_q_reg <= store_mem[mid_tag.addr[ADDR_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg <= out_tag.addr;
        fwd_data_reg <= new_val;
        if (rd_out) begin
            m_data_reg <= out_tag.ok ? old_val : '0;
            m_ovf_reg  <= ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_v_reg       <= 1'b0;
            ovf_reg         <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            rd_inflight_reg <= 1'b0;
        end else begin
            fwd_v_reg <= wr_en;
            if (wr_en && (out_sat || add_sat)) begin
                ovf_reg <= 1'b1;
            end
            if (rd_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (accept && s_tuser[0] == MODE_READ) begin
                rd_inflight_reg <= 1'b1;
            end else if (rd_out) begin
                rd_inflight_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'b0, m_ovf_reg, m_data_reg};

endmodule

@@ design/tsa_port_check.sv @@
// Port-level assertions for the triangle stiffness assembly block.
// Bound to triangle_stiffness_assembly; depends on tsa_pkg.
module tsa_port_check
    import tsa_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TUSER_W-1:0] s_tuser,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    // The memory clearing pass follows every reset, so no request is taken then.
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("request taken right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == MODE_READ |=> !m_tvalid)
        else $error("result appeared too early after a read request");

    a_add_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser[0] == MODE_ADD && s_tuser[1] |=> !s_tready)
        else $error("request taken while a triangle is still issuing");

endmodule

bind triangle_stiffness_assembly tsa_port_check u_port_check (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for triangle_stiffness_assembly over its stream ports.
// Depends on tsa_pkg and the RTL. Element adds are mirrored into a local matrix copy
// and each read request is checked against it or against a fixed expected value.
module tb;
    import tsa_pkg::*;

    localparam int NODE_COUNT = 64;
    localparam longint ENT_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ENT_LO = -ENT_HI - 1;

    typedef struct packed {
        logic                   mode;
        logic                   is_tri;
        logic [0:2][GRAD_W-1:0] gx;
        logic [0:2][GRAD_W-1:0] gy;
        logic [GRAD_W-1:0]      det;
        logic [0:2][NODE_W-1:0] node;
    } elem_req_t;

    typedef struct packed {
        logic [ENTRY_W-1:0] value;
        logic               flag;
    } entry_rd_t;

    typedef struct packed {
        elem_req_t req;
        logic      fixed;
        entry_rd_t due;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    longint    stiff_mirror [NODE_SPAN*NODE_SPAN];
    logic      sat_seen = 1'b0;
    entry_rd_t read_returns_due [$];
    dir_row_t  dir_rows [$];
    entry_rd_t due;
    int        src_idle_pct = 0;
    int        snk_stall_pct = 0;
    int        fail_cnt = 0;

    triangle_stiffness_assembly #(
        .NODES(NODE_COUNT)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // One local entry in Q24.24: half of |det| times the gradient dot product, rounded
    // to nearest with ties away from zero, saturated to the 48-bit range.
    function automatic longint pair_term(input logic signed [GRAD_W-1:0] gxi, gyi, gxj, gyj,
                                         input logic [GRAD_W-1:0] det_mag, output logic sat);
        logic signed [64:0] dot;
        logic [63:0]        mag;
        logic [127:0]       scaled;
        logic [127:0]       lim;
        logic               neg;
        dot = 65'(gxi) * 65'(gxj) + 65'(gyi) * 65'(gyj);
        neg = dot[64];
        mag = neg ? 64'(-dot) : 64'(dot);
        scaled = (128'(mag) * 128'(det_mag) + (128'd1 << 24)) >> 25;
        lim = neg ? (128'd1 << 47) : ((128'd1 << 47) - 128'd1);
        sat = 1'b0;
        if (scaled > lim) begin
            sat = 1'b1;
            scaled = lim;
        end
        return neg ? -longint'(scaled[63:0]) : longint'(scaled[63:0]);
    endfunction

    function automatic void mirror_request(input elem_req_t r);
        entry_rd_t         rd;
        logic [GRAD_W-1:0] det_mag;
        longint            loc;
        longint            acc;
        logic              sat;
        int                idx;
        if (r.mode == MODE_READ) begin
            rd.value = '0;
            if (r.node[0] < NODE_COUNT && r.node[1] < NODE_COUNT)
                rd.value = ENTRY_W'(stiff_mirror[r.node[0] * NODE_COUNT + r.node[1]]);
            rd.flag = sat_seen;
            read_returns_due.push_back(rd);
            return;
        end
        if (!r.is_tri)
            return;
        det_mag = r.det[GRAD_W-1] ? -r.det : r.det;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r.node[i] >= NODE_COUNT || r.node[j] >= NODE_COUNT)
                    continue;
                loc = pair_term(r.gx[i], r.gy[i], r.gx[j], r.gy[j], det_mag, sat);
                idx = r.node[i] * NODE_COUNT + r.node[j];
                acc = stiff_mirror[idx] + loc;
                if (acc > ENT_HI) begin
                    acc = ENT_HI;
                    sat = 1'b1;
                end else if (acc < ENT_LO) begin
                    acc = ENT_LO;
                    sat = 1'b1;
                end
                stiff_mirror[idx] = acc;
                if (sat)
                    sat_seen = 1'b1;
            end
        end
    endfunction

    function automatic logic [GRAD_W-1:0] rand_grad(input logic wide);
        if ($urandom_range(15) == 0) begin
            case ($urandom_range(wide ? 4 : 2))
                0: return '0;
                1: return 32'd1;
                2: return '1;
                3: return 32'h7FFF_FFFF;
                default: return 32'h8000_0000;
            endcase
        end
        if (wide)
            return $urandom;
        return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endfunction

    // Full-range elements land on high nodes so the small, dense corner of the
    // matrix keeps accumulating without being pinned at a saturation limit.
    function automatic logic [NODE_W-1:0] rand_node(input logic wide);
        if (wide)
            return NODE_W'($urandom_range(32, 63));
        if ($urandom_range(4) != 0)
            return NODE_W'($urandom_range(0, 7));
        return NODE_W'($urandom_range(0, 63));
    endfunction

    function automatic elem_req_t random_request();
        elem_req_t   r;
        int unsigned pick;
        logic        wide;
        pick = $urandom_range(99);
        wide = ($urandom_range(19) == 0);
        r.mode = (pick < 30) ? MODE_READ : MODE_ADD;
        r.is_tri = (pick < 30) ? 1'($urandom_range(1)) : (pick >= 38);
        for (int k = 0; k < 3; k++) begin
            r.gx[k] = rand_grad(wide);
            r.gy[k] = rand_grad(wide);
            r.node[k] = rand_node(wide);
        end
        r.det = rand_grad(wide);
        return r;
    endfunction

    function automatic void add_row(input logic is_tri,
                                    input logic [GRAD_W-1:0] gx0, gy0, gx1, gy1, gx2, gy2, det,
                                    input int na, nb, nc);
        dir_row_t row;
        row = '0;
        row.req.mode = MODE_ADD;
        row.req.is_tri = is_tri;
        row.req.gx = {gx0, gx1, gx2};
        row.req.gy = {gy0, gy1, gy2};
        row.req.det = det;
        row.req.node = {NODE_W'(na), NODE_W'(nb), NODE_W'(nc)};
        dir_rows.push_back(row);
    endfunction

    function automatic void read_row(input int r, c, input logic fixed,
                                     input logic [ENTRY_W-1:0] value, input logic flag);
        dir_row_t row;
        row = '0;
        row.req.mode = MODE_READ;
        row.req.node = {NODE_W'(r), NODE_W'(c), NODE_W'(0)};
        row.fixed = fixed;
        row.due.value = value;
        row.due.flag = flag;
        dir_rows.push_back(row);
    endfunction

    task automatic send_request(input elem_req_t r);
        logic [S_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 3; k++) begin
            d[2 * k * GRAD_W +: GRAD_W] = r.gx[k];
            d[(2 * k + 1) * GRAD_W +: GRAD_W] = r.gy[k];
            d[NODE_BASE + k * NODE_W +: NODE_W] = r.node[k];
        end
        d[DET_BASE +: GRAD_W] = r.det;
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        s_tuser <= {r.is_tri, r.mode};
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (read_returns_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got entry %h flag %b",
                         $time, m_tdata[ENTRY_W-1:0], m_tdata[ENTRY_W]);
                fail_cnt++;
            end else begin
                due = read_returns_due.pop_front();
                if (m_tdata[ENTRY_W-1:0] !== due.value) begin
                    $display("%0t: entry_value mismatch, expected %h, got %h",
                             $time, due.value, m_tdata[ENTRY_W-1:0]);
                    fail_cnt++;
                end
                if (m_tdata[ENTRY_W] !== due.flag) begin
                    $display("%0t: overflow_seen mismatch, expected %b, got %b",
                             $time, due.flag, m_tdata[ENTRY_W]);
                    fail_cnt++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end

    initial begin
        #5_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        int        counted;
        elem_req_t req;
        foreach (stiff_mirror[n])
            stiff_mirror[n] = 0;

        read_row(0, 0, 1'b1, '0, 1'b0);
        read_row(63, 63, 1'b1, '0, 1'b0);
        add_row(1'b0, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000,
                32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        read_row(0, 0, 1'b1, '0, 1'b0);
        add_row(1'b1, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000,
                32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 0, 1, 2);
        read_row(0, 0, 1'b1, 48'h0000_0100_0000, 1'b0);
        read_row(0, 1, 1'b1, 48'hFFFF_FF80_0000, 1'b0);
        read_row(1, 2, 1'b1, '0, 1'b0);
        add_row(1'b1, 32'hFFFF_0000, 32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000,
                32'h0000_0000, 32'h0001_0000, 32'hFFFF_0000, 0, 1, 2);
        read_row(0, 0, 1'b1, 48'h0000_0200_0000, 1'b0);
        add_row(1'b1, 32'h0003_8000, 32'hFFFE_4000, 32'h0000_0001, 32'hFFFF_FFFF,
                32'h0012_3456, 32'hFFED_CBAA, 32'h0000_C000, 5, 5, 5);
        read_row(5, 5, 1'b0, '0, 1'b0);
        add_row(1'b1, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0002,
                32'h0000_7FFF, 32'h0001_0000, 32'h0000_0001, 63, 42, 21);
        read_row(63, 42, 1'b0, '0, 1'b0);
        read_row(42, 21, 1'b0, '0, 1'b0);
        read_row(21, 63, 1'b0, '0, 1'b0);
        add_row(1'b1, 32'h0002_0000, 32'hFFFD_0000, 32'h0000_8000, 32'h0004_0000,
                32'hFFFF_8000, 32'h0000_0100, 32'h0000_0000, 21, 21, 63);
        read_row(21, 21, 1'b0, '0, 1'b0);
        add_row(1'b1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h0000_0000, 32'h0000_0000, 32'h8000_0000, 10, 11, 12);
        read_row(10, 10, 1'b1, ENTRY_MAX, 1'b1);
        read_row(10, 11, 1'b1, ENTRY_MIN, 1'b1);
        read_row(12, 12, 1'b1, '0, 1'b1);
        read_row(11, 11, 1'b1, ENTRY_MAX, 1'b1);
        add_row(1'b1, 32'h0000_1000, 32'hFFFF_F000, 32'h0000_0800, 32'h0000_0400,
                32'hFFFF_FC00, 32'h0000_0200, 32'h7FFF_FFFF, 3, 4, 6);
        read_row(3, 4, 1'b0, '0, 1'b0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[n]) begin
            send_request(dir_rows[n].req);
            if (dir_rows[n].fixed)
                read_returns_due.push_back(dir_rows[n].due);
            else
                mirror_request(dir_rows[n].req);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 0;
                end
                1: begin
                    src_idle_pct = 51;
                    snk_stall_pct = 0;
                end
                2: begin
                    src_idle_pct = 0;
                    snk_stall_pct = 51;
                end
                default: begin
                    src_idle_pct = 28;
                    snk_stall_pct = 28;
                end
            endcase
            counted = 0;
            while (counted < 213) begin
                req = random_request();
                send_request(req);
                mirror_request(req);
                if (req.mode == MODE_READ || req.is_tri)
                    counted++;
            end
        end
        s_tvalid <= 1'b0;

        while (read_returns_due.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/tsa_pkg.sv
design/tsa_entry_pipe.sv
design/triangle_stiffness_assembly.sv
design/tsa_port_check.sv
tb/tb.sv
